### src/mer_pkg.sv
package mer_pkg;

   // Width of the pixel colour carried from the start item to every pixel.
   localparam int COLOR_BITS = 24;

   // Operation codes on the input channel.
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Mirror pixel counter: the fourth pixel of a point closes the step.
   localparam logic [1:0] PIX_FIRST = 2'd0;
   localparam logic [1:0] PIX_LAST  = 2'd3;

   // Command kind after classification in the front part.
   typedef enum logic {
      CMD_START,
      CMD_STEP
   } cmd_kind_type;

   // Control group from the command queue to the back part.
   typedef struct packed {
      logic         valid;
      cmd_kind_type kind;
   } cmd_ctrl_type;

   // Back part sequencer.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_AB,
      ST_INIT0,
      ST_INIT1,
      ST_RC_TT,
      ST_RC_P1,
      ST_RC_YY,
      ST_RC_P2,
      ST_RC_P3,
      ST_RC_SUM,
      ST_RC_DIV,
      ST_EMIT
   } back_state_type;

endpackage

### src/mer_front.sv
module mer_front
   import mer_pkg::*;
#(
   parameter int COORD_BITS  = 11,
   parameter int RADIUS_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_operation,
   input  logic [COORD_BITS-1:0]  req_center_x,
   input  logic [COORD_BITS-1:0]  req_center_y,
   input  logic [RADIUS_BITS-1:0] req_radius_x,
   input  logic [RADIUS_BITS-1:0] req_radius_y,
   input  logic [COLOR_BITS-1:0]  req_color,
   output cmd_ctrl_type           cmd_ctrl,
   input  logic                   cmd_ready,
   output logic [COORD_BITS-1:0]  cmd_center_x,
   output logic [COORD_BITS-1:0]  cmd_center_y,
   output logic [RADIUS_BITS-1:0] cmd_radius_x,
   output logic [RADIUS_BITS-1:0] cmd_radius_y,
   output logic [COLOR_BITS-1:0]  cmd_color
);

   localparam logic [1:0] QUEUE_EMPTY = 2'd0;
   localparam logic [1:0] QUEUE_FULL  = 2'd2;

   logic [1:0]             count_ff, count_in;
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   cmd_kind_type           kind_ff [2];
   logic [COORD_BITS-1:0]  cx_ff [2];
   logic [COORD_BITS-1:0]  cy_ff [2];
   logic [RADIUS_BITS-1:0] rx_ff [2];
   logic [RADIUS_BITS-1:0] ry_ff [2];
   logic [COLOR_BITS-1:0]  color_ff [2];
   cmd_kind_type           kind_in;
   logic                   push;
   logic                   pop;

   // Classify the incoming item.
   assign kind_in = (req_operation == OP_START) ? CMD_START : CMD_STEP;

   assign req_tready = (count_ff != QUEUE_FULL);
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_ctrl.valid && cmd_ready;

   // Head of the queue towards the back part.
   assign cmd_ctrl.valid = (count_ff != QUEUE_EMPTY);
   assign cmd_ctrl.kind  = kind_ff[rd_ptr_ff];
   assign cmd_center_x   = cx_ff[rd_ptr_ff];
   assign cmd_center_y   = cy_ff[rd_ptr_ff];
   assign cmd_radius_x   = rx_ff[rd_ptr_ff];
   assign cmd_radius_y   = ry_ff[rd_ptr_ff];
   assign cmd_color      = color_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= QUEUE_EMPTY;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Queue storage, written at the tail.
   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff[wr_ptr_ff]  <= kind_in;
         cx_ff[wr_ptr_ff]    <= req_center_x;
         cy_ff[wr_ptr_ff]    <= req_center_y;
         rx_ff[wr_ptr_ff]    <= req_radius_x;
         ry_ff[wr_ptr_ff]    <= req_radius_y;
         color_ff[wr_ptr_ff] <= req_color;
      end
   end

endmodule

### src/mer_mul.sv
module mer_mul #(
   parameter int A_BITS = 20,
   parameter int B_BITS = 24
) (
   input  logic                     clock,
   input  logic [A_BITS-1:0]        op_a,
   input  logic [B_BITS-1:0]        op_b,
   output logic [A_BITS+B_BITS-1:0] prod_ff
);

   localparam int P_BITS = A_BITS + B_BITS;

   logic [P_BITS-1:0] prod_in;

   // Unsigned product, registered for use in the following cycle.
   assign prod_in = P_BITS'(op_a) * P_BITS'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### src/mer_back.sv
module mer_back
   import mer_pkg::*;
#(
   parameter int COORD_BITS  = 11,
   parameter int RADIUS_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_ctrl_type            cmd_ctrl,
   output logic                    cmd_ready,
   input  logic [COORD_BITS-1:0]   cmd_center_x,
   input  logic [COORD_BITS-1:0]   cmd_center_y,
   input  logic [RADIUS_BITS-1:0]  cmd_radius_x,
   input  logic [RADIUS_BITS-1:0]  cmd_radius_y,
   input  logic [COLOR_BITS-1:0]   cmd_color,
   output logic                    pix_valid,
   input  logic                    pix_ready,
   output logic [COORD_BITS+1:0]   pix_x,
   output logic [COORD_BITS+1:0]   pix_y,
   output logic [COLOR_BITS-1:0]   pix_color,
   output logic                    pix_last,
   output logic                    pix_done
);

   localparam int R  = RADIUS_BITS;
   localparam int C  = COORD_BITS;
   localparam int OW = R + 1;          // point offsets
   localparam int SQ = 2 * R;          // squared semi-axes
   localparam int KW = 2 * R + 2;      // doubled and tripled squares
   localparam int GW = 3 * R + 4;      // gradients 2b^2x and 2a^2y
   localparam int DW = 4 * R + 8;      // decision variable
   localparam int MA = 2 * R;
   localparam int MB = 2 * R + 4;
   localparam int MP = MA + MB;
   localparam int PW = C + 2;
   localparam int EW = (PW > R + 2) ? PW : R + 2;

   back_state_type           state_ff, state_in;
   logic [1:0]               idx_ff, idx_in;
   logic                     active_ff, active_in;
   logic                     region_two_ff, region_two_in;
   logic [C-1:0]             center_col_ff, center_col_in;
   logic [C-1:0]             center_row_ff, center_row_in;
   logic [COLOR_BITS-1:0]    color_ff, color_in;
   logic [R-1:0]             rad_a_ff, rad_a_in;
   logic [R-1:0]             rad_b_ff, rad_b_in;
   logic [SQ-1:0]            a2_ff, a2_in;
   logic [SQ-1:0]            b2_ff, b2_in;
   logic [KW-1:0]            a2x2_ff, a2x2_in;
   logic [KW-1:0]            a2x3_ff, a2x3_in;
   logic [KW-1:0]            b2x2_ff, b2x2_in;
   logic [KW-1:0]            b2x3_ff, b2x3_in;
   logic [OW-1:0]            offset_x_ff, offset_x_in;
   logic signed [OW-1:0]     offset_y_ff, offset_y_in;
   logic signed [GW-1:0]     grad_x_ff, grad_x_in;
   logic signed [GW-1:0]     grad_y_ff, grad_y_in;
   logic signed [DW-1:0]     decision_ff, decision_in;
   logic signed [DW-1:0]     acc_ff, acc_in;
   logic                     pix_valid_ff, pix_valid_in;
   logic [PW-1:0]            pix_x_ff, pix_x_in;
   logic [PW-1:0]            pix_y_ff, pix_y_in;
   logic [COLOR_BITS-1:0]    pix_color_ff, pix_color_in;
   logic                     pix_last_ff, pix_last_in;
   logic                     pix_done_ff, pix_done_in;

   logic [MA-1:0]            mul_a;
   logic [MB-1:0]            mul_b;
   logic [MP-1:0]            mul_prod;

   logic                     out_free;
   logic                     grad_x_lt_y;
   logic                     d_neg;
   logic                     d_pos;
   logic                     y_zero;
   logic                     y_le_zero;
   logic [OW:0]              t_odd;
   logic [OW-1:0]            y_less;
   logic signed [DW-1:0]     grad_x_e;
   logic signed [DW-1:0]     grad_y_e;
   logic signed [DW-1:0]     term_val;
   logic                     term_sub;
   logic signed [DW-1:0]     acc_base;
   logic signed [DW-1:0]     acc_next;
   logic signed [DW-1:0]     rnd;
   logic [EW-1:0]            cx_e, cy_e, ox_e, oy_e;
   logic [EW-1:0]            px_full, py_full;

   mer_mul #(
      .A_BITS (MA),
      .B_BITS (MB)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_prod)
   );

   // Status of the current point and decision variable.
   assign out_free    = !pix_valid_ff || pix_ready;
   assign grad_x_lt_y = grad_x_ff < grad_y_ff;
   assign d_neg       = decision_ff[DW-1];
   assign d_pos       = !d_neg && (decision_ff != '0);
   assign y_zero      = (offset_y_ff == '0);
   assign y_le_zero   = y_zero || offset_y_ff[OW-1];
   assign t_odd       = {offset_x_ff, 1'b1};
   assign y_less      = y_zero ? OW'(1) : offset_y_ff - OW'(1);
   assign grad_x_e    = {{(DW-GW){grad_x_ff[GW-1]}}, grad_x_ff};
   assign grad_y_e    = {{(DW-GW){grad_y_ff[GW-1]}}, grad_y_ff};
   assign rnd         = acc_ff + (acc_ff[DW-1] ? DW'(3) : DW'(0));

   // Mirror pixel coordinates, wrapped to the pixel width.
   assign cx_e    = {{(EW-C){1'b0}}, center_col_ff};
   assign cy_e    = {{(EW-C){1'b0}}, center_row_ff};
   assign ox_e    = {{(EW-OW){1'b0}}, offset_x_ff};
   assign oy_e    = {{(EW-OW){offset_y_ff[OW-1]}}, offset_y_ff};
   assign px_full = idx_ff[0] ? cx_e - ox_e : cx_e + ox_e;
   assign py_full = idx_ff[1] ? cy_e - oy_e : cy_e + oy_e;

   // One term of the decision update is added or subtracted for each mirror pixel sent.
   always_comb begin
      term_val = '0;
      term_sub = 1'b0;
      if (!region_two_ff) begin
         case (idx_ff)
            2'd0: term_val = grad_x_e;
            2'd1: term_val = {{(DW-KW){1'b0}}, b2x3_ff};
            2'd2: begin
               if (!d_neg) begin
                  term_val = grad_y_e;
                  term_sub = 1'b1;
               end
            end
            default: begin
               if (!d_neg) begin
                  term_val = {{(DW-KW){1'b0}}, a2x2_ff};
               end
            end
         endcase
      end else if (d_pos) begin
         case (idx_ff)
            2'd0: term_val = {{(DW-KW){1'b0}}, a2x3_ff};
            2'd1: begin
               term_val = grad_y_e;
               term_sub = 1'b1;
            end
            default: term_val = '0;
         endcase
      end else begin
         case (idx_ff)
            2'd0: term_val = grad_x_e;
            2'd1: term_val = {{(DW-KW){1'b0}}, b2x2_ff};
            2'd2: term_val = {{(DW-KW){1'b0}}, a2x3_ff};
            default: begin
               term_val = grad_y_e;
               term_sub = 1'b1;
            end
         endcase
      end
      acc_base = (idx_ff == PIX_FIRST) ? decision_ff : acc_ff;
      acc_next = term_sub ? acc_base - term_val : acc_base + term_val;
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_ctrl.valid) begin
               if (cmd_ctrl.kind == CMD_START) begin
                  state_in = ST_SQ_A;
               end else if (!active_ff) begin
                  state_in = ST_IDLE;
               end else if (!region_two_ff && !grad_x_lt_y) begin
                  state_in = ST_RC_TT;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SQ_A:   state_in = ST_SQ_B;
         ST_SQ_B:   state_in = ST_AB;
         ST_AB:     state_in = ST_INIT0;
         ST_INIT0:  state_in = ST_INIT1;
         ST_INIT1:  state_in = ST_IDLE;
         ST_RC_TT:  state_in = ST_RC_P1;
         ST_RC_P1:  state_in = ST_RC_YY;
         ST_RC_YY:  state_in = ST_RC_P2;
         ST_RC_P2:  state_in = ST_RC_P3;
         ST_RC_P3:  state_in = ST_RC_SUM;
         ST_RC_SUM: state_in = ST_RC_DIV;
         ST_RC_DIV: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free && idx_ff == PIX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs for each state.
   always_comb begin
      cmd_ready     = (state_ff == ST_IDLE);
      mul_a         = '0;
      mul_b         = '0;
      idx_in        = idx_ff;
      active_in     = active_ff;
      region_two_in = region_two_ff;
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      color_in      = color_ff;
      rad_a_in      = rad_a_ff;
      rad_b_in      = rad_b_ff;
      a2_in         = a2_ff;
      b2_in         = b2_ff;
      a2x2_in       = a2x2_ff;
      a2x3_in       = a2x3_ff;
      b2x2_in       = b2x2_ff;
      b2x3_in       = b2x3_ff;
      offset_x_in   = offset_x_ff;
      offset_y_in   = offset_y_ff;
      grad_x_in     = grad_x_ff;
      grad_y_in     = grad_y_ff;
      decision_in   = decision_ff;
      acc_in        = acc_ff;
      pix_valid_in  = pix_valid_ff && !pix_ready;
      pix_x_in      = pix_x_ff;
      pix_y_in      = pix_y_ff;
      pix_color_in  = pix_color_ff;
      pix_last_in   = pix_last_ff;
      pix_done_in   = pix_done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = PIX_FIRST;
            if (cmd_ctrl.valid && cmd_ctrl.kind == CMD_START) begin
               center_col_in = cmd_center_x;
               center_row_in = cmd_center_y;
               color_in      = cmd_color;
               rad_a_in      = cmd_radius_x;
               rad_b_in      = cmd_radius_y;
            end
         end
         // Start: a^2, b^2 and a^2*b through the shared multiplier.
         ST_SQ_A: begin
            mul_a = {{(MA-R){1'b0}}, rad_a_ff};
            mul_b = {{(MB-R){1'b0}}, rad_a_ff};
         end
         ST_SQ_B: begin
            a2_in = mul_prod[SQ-1:0];
            mul_a = {{(MA-R){1'b0}}, rad_b_ff};
            mul_b = {{(MB-R){1'b0}}, rad_b_ff};
         end
         ST_AB: begin
            b2_in = mul_prod[SQ-1:0];
            mul_a = a2_ff;
            mul_b = {{(MB-R){1'b0}}, rad_b_ff};
         end
         ST_INIT0: begin
            grad_y_in = {mul_prod[GW-2:0], 1'b0};
            acc_in    = {{(DW-SQ){1'b0}}, b2_ff} - {{(DW-MP){1'b0}}, mul_prod};
            a2x2_in   = {1'b0, a2_ff, 1'b0};
            a2x3_in   = {2'b00, a2_ff} + {1'b0, a2_ff, 1'b0};
            b2x2_in   = {1'b0, b2_ff, 1'b0};
            b2x3_in   = {2'b00, b2_ff} + {1'b0, b2_ff, 1'b0};
         end
         ST_INIT1: begin
            decision_in   = acc_ff + {{(DW-SQ+2){1'b0}}, a2_ff[SQ-1:2]};
            offset_x_in   = '0;
            offset_y_in   = {1'b0, rad_b_ff};
            grad_x_in     = '0;
            region_two_in = 1'b0;
            active_in     = 1'b1;
         end
         // Region change: b^2(2x+1)^2 + 4a^2(y-1)^2 - 4a^2b^2, then a quarter.
         ST_RC_TT: begin
            mul_a = {{(MA-OW-1){1'b0}}, t_odd};
            mul_b = {{(MB-OW-1){1'b0}}, t_odd};
         end
         ST_RC_P1: begin
            mul_a = b2_ff;
            mul_b = mul_prod[MB-1:0];
         end
         ST_RC_YY: begin
            acc_in = {{(DW-MP){1'b0}}, mul_prod};
            mul_a  = {{(MA-OW){1'b0}}, y_less};
            mul_b  = {{(MB-OW){1'b0}}, y_less};
         end
         ST_RC_P2: begin
            mul_a = a2_ff;
            mul_b = mul_prod[MB-1:0];
         end
         ST_RC_P3: begin
            acc_in = acc_ff + {{(DW-MP-2){1'b0}}, mul_prod, 2'b00};
            mul_a  = a2_ff;
            mul_b  = {{(MB-SQ){1'b0}}, b2_ff};
         end
         ST_RC_SUM: begin
            acc_in = acc_ff - {{(DW-MP-2){1'b0}}, mul_prod, 2'b00};
         end
         ST_RC_DIV: begin
            decision_in   = {{2{rnd[DW-1]}}, rnd[DW-1:2]};
            region_two_in = 1'b1;
         end
         // One mirror pixel per free output slot, update folded in.
         ST_EMIT: begin
            if (out_free) begin
               pix_valid_in = 1'b1;
               pix_x_in     = px_full[PW-1:0];
               pix_y_in     = py_full[PW-1:0];
               pix_color_in = color_ff;
               pix_last_in  = (idx_ff == PIX_LAST);
               pix_done_in  = region_two_ff && y_zero;
               idx_in       = idx_ff + 2'd1;
               acc_in       = acc_next;
               if (idx_ff == PIX_LAST) begin
                  decision_in = acc_next;
                  if (region_two_ff ? !d_pos : 1'b1) begin
                     offset_x_in = offset_x_ff + OW'(1);
                     grad_x_in   = grad_x_ff + {{(GW-KW){1'b0}}, b2x2_ff};
                  end
                  if (region_two_ff ? 1'b1 : !d_neg) begin
                     offset_y_in = offset_y_ff - OW'(1);
                     grad_y_in   = grad_y_ff - {{(GW-KW){1'b0}}, a2x2_ff};
                  end
                  if (region_two_ff && y_le_zero) begin
                     active_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            idx_in = PIX_FIRST;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= PIX_FIRST;
         active_ff     <= 1'b0;
         region_two_ff <= 1'b0;
         pix_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         active_ff     <= active_in;
         region_two_ff <= region_two_in;
         pix_valid_ff  <= pix_valid_in;
      end
   end

   // Ellipse parameters, decision variable and output payload.
   always_ff @(posedge clock) begin
      center_col_ff <= center_col_in;
      center_row_ff <= center_row_in;
      color_ff      <= color_in;
      rad_a_ff      <= rad_a_in;
      rad_b_ff      <= rad_b_in;
      a2_ff         <= a2_in;
      b2_ff         <= b2_in;
      a2x2_ff       <= a2x2_in;
      a2x3_ff       <= a2x3_in;
      b2x2_ff       <= b2x2_in;
      b2x3_ff       <= b2x3_in;
      offset_x_ff   <= offset_x_in;
      offset_y_ff   <= offset_y_in;
      grad_x_ff     <= grad_x_in;
      grad_y_ff     <= grad_y_in;
      decision_ff   <= decision_in;
      acc_ff        <= acc_in;
      pix_x_ff      <= pix_x_in;
      pix_y_ff      <= pix_y_in;
      pix_color_ff  <= pix_color_in;
      pix_last_ff   <= pix_last_in;
      pix_done_ff   <= pix_done_in;
   end

   assign pix_valid = pix_valid_ff;
   assign pix_x     = pix_x_ff;
   assign pix_y     = pix_y_ff;
   assign pix_color = pix_color_ff;
   assign pix_last  = pix_last_ff;
   assign pix_done  = pix_done_ff;

endmodule

### src/midpoint_ellipse_rasterizer.sv
// Channel   Direction  Contents
// req_      in         tuser: operation; tdata: center_x, center_y, radius_x, radius_y, color
// rsp_      out        tuser: ellipse_done; tlast: last_of_step; tdata: pixel_x, pixel_y, colour
//
// A start item occupies the back part through SQ_A, SQ_B, AB, INIT0 and INIT1 (three products
// from one multiplier). A step item is taken from the queue, then four mirror pixels go out
// through the single output register while rsp_tready is high; the step that enters region two
// first runs the region-two decision, and a step with no ellipse in progress is only dequeued.
// Reset is synchronous: the queue empties, no ellipse is active and no pixel is pending.
// rsp_tready low holds the pixel sequencer; the two-entry queue keeps accepting until full.
module midpoint_ellipse_rasterizer
   import mer_pkg::*;
#(
   parameter int COORD_BITS  = 11,
   parameter int RADIUS_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // center_x, center_y, radius_x, radius_y, color, zero padding
   input  logic [((2*COORD_BITS+2*RADIUS_BITS+COLOR_BITS+7)/8)*8-1:0] req_tdata,
   // operation
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pixel_x, pixel_y, pixel_color, zero padding
   output logic [((2*(COORD_BITS+2)+COLOR_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast,
   // ellipse_done
   output logic [0:0] rsp_tuser
);

   localparam int C         = COORD_BITS;
   localparam int R         = RADIUS_BITS;
   localparam int PW        = C + 2;
   localparam int OUT_BITS  = 2 * PW + COLOR_BITS;
   localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

   logic [C-1:0]          req_center_x, req_center_y;
   logic [R-1:0]          req_radius_x, req_radius_y;
   logic [COLOR_BITS-1:0] req_color;
   cmd_ctrl_type          cmd_ctrl;
   logic                  cmd_ready;
   logic [C-1:0]          cmd_center_x, cmd_center_y;
   logic [R-1:0]          cmd_radius_x, cmd_radius_y;
   logic [COLOR_BITS-1:0] cmd_color;
   logic [PW-1:0]         pix_x, pix_y;
   logic [COLOR_BITS-1:0] pix_color;
   logic                  pix_done;

   // Unpack the input item.
   assign req_center_x = req_tdata[C-1:0];
   assign req_center_y = req_tdata[2*C-1:C];
   assign req_radius_x = req_tdata[2*C+R-1:2*C];
   assign req_radius_y = req_tdata[2*C+2*R-1:2*C+R];
   assign req_color    = req_tdata[2*C+2*R+COLOR_BITS-1:2*C+2*R];

   mer_front #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_operation (req_tuser[0]),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius_x  (req_radius_x),
      .req_radius_y  (req_radius_y),
      .req_color     (req_color),
      .cmd_ctrl      (cmd_ctrl),
      .cmd_ready     (cmd_ready),
      .cmd_center_x  (cmd_center_x),
      .cmd_center_y  (cmd_center_y),
      .cmd_radius_x  (cmd_radius_x),
      .cmd_radius_y  (cmd_radius_y),
      .cmd_color     (cmd_color)
   );

   mer_back #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_ctrl     (cmd_ctrl),
      .cmd_ready    (cmd_ready),
      .cmd_center_x (cmd_center_x),
      .cmd_center_y (cmd_center_y),
      .cmd_radius_x (cmd_radius_x),
      .cmd_radius_y (cmd_radius_y),
      .cmd_color    (cmd_color),
      .pix_valid    (rsp_tvalid),
      .pix_ready    (rsp_tready),
      .pix_x        (pix_x),
      .pix_y        (pix_y),
      .pix_color    (pix_color),
      .pix_last     (rsp_tlast),
      .pix_done     (pix_done)
   );

   assign rsp_tuser[0] = pix_done;

   // Pack the result item, padded with zeros to whole bytes.
   if (OUT_TDATA > OUT_BITS) begin : g_pad
      assign rsp_tdata = {{(OUT_TDATA-OUT_BITS){1'b0}}, pix_color, pix_y, pix_x};
   end else begin : g_nopad
      assign rsp_tdata = {pix_color, pix_y, pix_x};
   end

endmodule
